// ----- rtl/core/shape_pair_contact_events_defines.svh -----
// Assertion macros for the shape pair contact event RTL.
`ifndef SHAPE_PAIR_CONTACT_EVENTS_DEFINES_SVH
`define SHAPE_PAIR_CONTACT_EVENTS_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SPCE_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SPCE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SPCE_ASSERT_IMPL(label, ante, cons, msg)

`define SPCE_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ----- rtl/core/spce_pkg.sv -----
// Types and constants for the shape pair contact event block.
package spce_pkg;

  localparam int PAIR_COUNT = 256;
  localparam int IDX_W      = (PAIR_COUNT > 1) ? $clog2(PAIR_COUNT) : 1;

  typedef enum logic [1:0] {
    FN_CIRC_CIRC,
    FN_BOX_BOX,
    FN_CIRC_BOX,
    FN_BOX_CIRC
  } func_t;

  typedef enum logic [1:0] {
    EV_NONE,
    EV_ENTER,
    EV_STAY,
    EV_EXIT
  } event_t;

  typedef struct packed {
    func_t             func;
    logic [IDX_W-1:0]  idx;
    logic signed [15:0] a_x;
    logic signed [15:0] a_y;
    logic [14:0]       a_w;
    logic [14:0]       a_h;
    logic signed [15:0] b_x;
    logic signed [15:0] b_y;
    logic [14:0]       b_w;
    logic [14:0]       b_h;
    logic              a_trigger;
    logic              b_trigger;
  } pair_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
    logic             hit;
    logic             first_trig;
    logic             second_trig;
  } ovl_res_t;

endpackage

// ----- rtl/core/spce_in_if.sv -----
// Input channel: one collider pair per transfer.
interface spce_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        func;
  logic [7:0]        pair_id;
  logic signed [15:0] a_x;
  logic signed [15:0] a_y;
  logic [14:0]       a_w;
  logic [14:0]       a_h;
  logic signed [15:0] b_x;
  logic signed [15:0] b_y;
  logic [14:0]       b_w;
  logic [14:0]       b_h;
  logic              a_trigger;
  logic              b_trigger;

  modport source (
    output valid, func, pair_id, a_x, a_y, a_w, a_h, b_x, b_y, b_w, b_h,
           a_trigger, b_trigger,
    input  ready
  );

  modport sink (
    input  valid, func, pair_id, a_x, a_y, a_w, a_h, b_x, b_y, b_w, b_h,
           a_trigger, b_trigger,
    output ready
  );
endinterface

// ----- rtl/core/spce_out_if.sv -----
// Result channel: overlap flag and contact events per transfer.
interface spce_out_if;
  logic       valid;
  logic       ready;
  logic       hit;
  logic [1:0] first_event;
  logic       first_is_trigger;
  logic [1:0] second_event;
  logic       second_is_trigger;

  modport source (
    output valid, hit, first_event, first_is_trigger, second_event,
           second_is_trigger,
    input  ready
  );

  modport sink (
    input  valid, hit, first_event, first_is_trigger, second_event,
           second_is_trigger,
    output ready
  );
endinterface

// ----- rtl/core/spce_overlap.sv -----
// Three-stage overlap test pipeline for circle and box pairs.
module spce_overlap (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_valid,
  input  spce_pkg::pair_t          item,
  output logic [spce_pkg::IDX_W-1:0] rd_idx,
  output spce_pkg::ovl_res_t       res
);
  import spce_pkg::*;

  // stage 1: operands after swap
  logic               s1_valid_r;
  logic               s1_cc_r;
  logic               s1_bb_r;
  logic [IDX_W-1:0]   s1_idx_r;
  logic signed [15:0] s1_ax_r, s1_ay_r, s1_bx_r, s1_by_r;
  logic [14:0]        s1_aw_r, s1_ah_r, s1_bw_r, s1_bh_r;
  logic               s1_at_r, s1_bt_r;
  logic               swap;

  assign swap = (item.func == FN_BOX_CIRC);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_cc_r  <= (item.func == FN_CIRC_CIRC);
      s1_bb_r  <= (item.func == FN_BOX_BOX);
      s1_idx_r <= item.idx;
      s1_ax_r  <= swap ? item.b_x : item.a_x;
      s1_ay_r  <= swap ? item.b_y : item.a_y;
      s1_aw_r  <= swap ? item.b_w : item.a_w;
      s1_ah_r  <= swap ? item.b_h : item.a_h;
      s1_bx_r  <= swap ? item.a_x : item.b_x;
      s1_by_r  <= swap ? item.a_y : item.b_y;
      s1_bw_r  <= swap ? item.a_w : item.b_w;
      s1_bh_r  <= swap ? item.a_h : item.b_h;
      s1_at_r  <= swap ? item.b_trigger : item.a_trigger;
      s1_bt_r  <= swap ? item.a_trigger : item.b_trigger;
    end
  end

  // stage 1 logic: box edges, differences, clamps
  logic signed [16:0] ax_e, ay_e, bx_e, by_e;
  logic signed [16:0] ax_hi, ay_hi, bx_hi, by_hi;
  logic signed [16:0] cx, cy;
  logic signed [17:0] dx_nxt, dy_nxt;
  logic [15:0]        r_nxt;
  logic               box_hit_nxt;

  always_comb begin
    ax_e  = 17'(s1_ax_r);
    ay_e  = 17'(s1_ay_r);
    bx_e  = 17'(s1_bx_r);
    by_e  = 17'(s1_by_r);
    ax_hi = ax_e + $signed({2'b00, s1_aw_r});
    ay_hi = ay_e + $signed({2'b00, s1_ah_r});
    bx_hi = bx_e + $signed({2'b00, s1_bw_r});
    by_hi = by_e + $signed({2'b00, s1_bh_r});
    box_hit_nxt = (ax_hi > bx_e) && (ax_e < bx_hi) && (ay_hi > by_e) && (ay_e < by_hi);
    // closest point of the box to the circle centre
    cx = (ax_e < bx_e) ? bx_e : ((ax_e > bx_hi) ? bx_hi : ax_e);
    cy = (ay_e < by_e) ? by_e : ((ay_e > by_hi) ? by_hi : ay_e);
    if (s1_cc_r) begin
      dx_nxt = 18'(ax_e) - 18'(bx_e);
      dy_nxt = 18'(ay_e) - 18'(by_e);
      r_nxt  = {1'b0, s1_aw_r} + {1'b0, s1_bw_r};
    end else begin
      dx_nxt = 18'(ax_e) - 18'(cx);
      dy_nxt = 18'(ay_e) - 18'(cy);
      r_nxt  = {1'b0, s1_aw_r};
    end
  end

  // stage 2: differences and radius
  logic               s2_valid_r;
  logic               s2_bb_r;
  logic               s2_box_hit_r;
  logic [IDX_W-1:0]   s2_idx_r;
  logic signed [17:0] s2_dx_r, s2_dy_r;
  logic [15:0]        s2_r_r;
  logic               s2_at_r, s2_bt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_bb_r      <= s1_bb_r;
      s2_box_hit_r <= box_hit_nxt;
      s2_idx_r     <= s1_idx_r;
      s2_dx_r      <= dx_nxt;
      s2_dy_r      <= dy_nxt;
      s2_r_r       <= r_nxt;
      s2_at_r      <= s1_at_r;
      s2_bt_r      <= s1_bt_r;
    end
  end

  assign rd_idx = s2_idx_r;

  // stage 2 logic: squares, each below 2^32
  logic signed [35:0] px, py;
  logic [31:0]        rr_nxt;

  assign px     = s2_dx_r * s2_dx_r;
  assign py     = s2_dy_r * s2_dy_r;
  assign rr_nxt = s2_r_r * s2_r_r;

  // stage 3: squares
  logic             s3_valid_r;
  logic             s3_bb_r;
  logic             s3_box_hit_r;
  logic [IDX_W-1:0] s3_idx_r;
  logic [31:0]      s3_sqx_r, s3_sqy_r, s3_rr_r;
  logic             s3_at_r, s3_bt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (en) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_bb_r      <= s2_bb_r;
      s3_box_hit_r <= s2_box_hit_r;
      s3_idx_r     <= s2_idx_r;
      s3_sqx_r     <= px[31:0];
      s3_sqy_r     <= py[31:0];
      s3_rr_r      <= rr_nxt;
      s3_at_r      <= s2_at_r;
      s3_bt_r      <= s2_bt_r;
    end
  end

  logic [32:0] dist2;

  assign dist2 = {1'b0, s3_sqx_r} + {1'b0, s3_sqy_r};

  always_comb begin
    res.valid       = s3_valid_r;
    res.idx         = s3_idx_r;
    res.hit         = s3_bb_r ? s3_box_hit_r : (dist2 < {1'b0, s3_rr_r});
    res.first_trig  = s3_at_r;
    res.second_trig = s3_bt_r;
  end

endmodule

// ----- rtl/core/shape_pair_contact_events.sv -----
// Top level: collider pair overlap test with per-pair contact events.
//
// Usage:
//   in_s takes one collider pair per transfer (valid/ready). A box-circle
//   pair is swapped so the circle is the first side, trigger flags too.
//   out_s delivers one result per pair, in order: the overlap flag, an
//   enter/stay/exit/none event for each side and the side's trigger flag.
//   Coordinates and sizes are Q12.4; all overlap compares are strict.
// Timing:
//   One pair is accepted every cycle while the output is not stalled;
//   the contact memory is read one stage ahead and written in the stage
//   after, with forwarding of the last write so back-to-back pairs with
//   the same pair_id see each other's update.
// Reset:
//   rst_n (synchronous, active low) empties the pipeline and marks every
//   contact entry as clear through per-entry valid bits; no clearing pass.
// Stall:
//   While a result waits and out_s.ready is low, the whole pipeline holds
//   and in_s.ready drops; nothing is lost or repeated.
`include "shape_pair_contact_events_defines.svh"

module shape_pair_contact_events (
  input  logic      clk,
  input  logic      rst_n,
  spce_in_if.sink   in_s,
  spce_out_if.source out_s
);
  import spce_pkg::*;

  // Pipeline advances whenever the output register is free or being taken.
  logic adv;
  logic out_valid_r;

  assign adv        = !out_valid_r || out_s.ready;
  assign in_s.ready = adv;

  // Pack the input transfer; the pair index wraps to the table size.
  pair_t item;

  always_comb begin
    item.func      = func_t'(in_s.func);
    item.idx       = IDX_W'(in_s.pair_id);
    item.a_x       = in_s.a_x;
    item.a_y       = in_s.a_y;
    item.a_w       = in_s.a_w;
    item.a_h       = in_s.a_h;
    item.b_x       = in_s.b_x;
    item.b_y       = in_s.b_y;
    item.b_w       = in_s.b_w;
    item.b_h       = in_s.b_h;
    item.a_trigger = in_s.a_trigger;
    item.b_trigger = in_s.b_trigger;
  end

  logic [IDX_W-1:0] rd_idx;
  ovl_res_t         s3;

  spce_overlap u_overlap (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (in_s.valid),
    .item     (item),
    .rd_idx   (rd_idx),
    .res      (s3)
  );

  // Contact memory: bit 0 first side, bit 1 second side. Entries not yet
  // written since reset read as clear through the valid bits.
  logic [1:0]            contact_mem [PAIR_COUNT];
  logic [PAIR_COUNT-1:0] ent_vld_r;
  logic [1:0]            rd_data_r;
  logic                  rd_vld_r;
  logic                  wr_en;
  logic [1:0]            wr_data;

  assign wr_en   = adv && s3.valid;
  assign wr_data = {s3.hit, s3.hit};

  // Read for the item moving into the last overlap stage; hold on stall.
  always_ff @(posedge clk) begin
    if (adv) begin
      rd_data_r <= contact_mem[rd_idx];
      rd_vld_r  <= ent_vld_r[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      contact_mem[s3.idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= '0;
    end else if (wr_en) begin
      ent_vld_r[s3.idx] <= 1'b1;
    end
  end

  // Last write, kept for forwarding: the read above misses a write made
  // at the same edge.
  logic             wr_valid_r;
  logic [IDX_W-1:0] wr_idx_r;
  logic [1:0]       wr_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_valid_r <= 1'b0;
    end else if (adv) begin
      wr_valid_r <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      wr_idx_r  <= s3.idx;
      wr_data_r <= wr_data;
    end
  end

  logic       fwd_hit;
  logic [1:0] cur_bits;
  event_t     first_ev, second_ev;

  assign fwd_hit  = wr_valid_r && (wr_idx_r == s3.idx);
  assign cur_bits = fwd_hit ? wr_data_r : (rd_vld_r ? rd_data_r : 2'b00);

  // Enter on a new contact, stay while it lasts, exit when it ends.
  always_comb begin
    unique case ({s3.hit, cur_bits[0]})
      2'b11:   first_ev = EV_STAY;
      2'b10:   first_ev = EV_ENTER;
      2'b01:   first_ev = EV_EXIT;
      default: first_ev = EV_NONE;
    endcase
    unique case ({s3.hit, cur_bits[1]})
      2'b11:   second_ev = EV_STAY;
      2'b10:   second_ev = EV_ENTER;
      2'b01:   second_ev = EV_EXIT;
      default: second_ev = EV_NONE;
    endcase
  end

  // Output register: load on advance, hold while the receiver stalls.
  logic   out_hit_r;
  event_t out_ev1_r, out_ev2_r;
  logic   out_trg1_r, out_trg2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s3.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      out_hit_r  <= s3.hit;
      out_ev1_r  <= first_ev;
      out_ev2_r  <= second_ev;
      out_trg1_r <= s3.first_trig;
      out_trg2_r <= s3.second_trig;
    end
  end

  assign out_s.valid             = out_valid_r;
  assign out_s.hit               = out_hit_r;
  assign out_s.first_event       = out_ev1_r;
  assign out_s.first_is_trigger  = out_trg1_r;
  assign out_s.second_event      = out_ev2_r;
  assign out_s.second_is_trigger = out_trg2_r;

  `SPCE_ASSERT_IMPL(a_stall_only_when_full, !in_s.ready, out_valid_r, "input stalled with empty output register")
  `SPCE_ASSERT_IMPL(a_side_bits_agree, wr_valid_r, wr_data_r[0] == wr_data_r[1], "contact bits of one pair disagree")
  `SPCE_ASSERT_NEXT(a_result_loaded, wr_en, out_valid_r && (out_hit_r == $past(s3.hit)), "result not loaded into output register")
  `SPCE_ASSERT_IMPL(a_forward_stay, s3.valid && fwd_hit && wr_data_r[0] && s3.hit, first_ev == EV_STAY, "forwarded contact did not give stay")

endmodule

// ----- tb/shape_pair_contact_events_tb.sv -----
// Self-checking testbench for the shape pair overlap and contact event block.
`timescale 1ns / 100ps

module shape_pair_contact_events_tb;
  import spce_pkg::*;

  // One collider pair as offered on the input channel.
  typedef struct {
    func_t              func;
    logic [7:0]         pair_id;
    logic signed [15:0] a_x;
    logic signed [15:0] a_y;
    logic [14:0]        a_w;
    logic [14:0]        a_h;
    logic signed [15:0] b_x;
    logic signed [15:0] b_y;
    logic [14:0]        b_w;
    logic [14:0]        b_h;
    logic               a_trigger;
    logic               b_trigger;
  } collider_pair_t;

  // One result as seen on the output channel.
  typedef struct packed {
    logic   hit;
    event_t first_event;
    logic   first_is_trigger;
    event_t second_event;
    logic   second_is_trigger;
  } contact_result_t;

  localparam int RANDOM_PER_PHASE = 610;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES    = 20;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  spce_in_if  in_ch ();
  spce_out_if out_ch ();

  shape_pair_contact_events i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_ch),
    .out_s (out_ch)
  );

  // Input side: the driver owns send_valid and offered; the payload follows offered.
  logic           send_valid = 1'b0;
  logic           recv_ready = 1'b0;
  collider_pair_t offered = '{FN_CIRC_CIRC, 8'd0, 16'sd0, 16'sd0, 15'd0, 15'd0,
                              16'sd0, 16'sd0, 15'd0, 15'd0, 1'b0, 1'b0};

  assign in_ch.valid     = send_valid;
  assign in_ch.func      = offered.func;
  assign in_ch.pair_id   = offered.pair_id;
  assign in_ch.a_x       = offered.a_x;
  assign in_ch.a_y       = offered.a_y;
  assign in_ch.a_w       = offered.a_w;
  assign in_ch.a_h       = offered.a_h;
  assign in_ch.b_x       = offered.b_x;
  assign in_ch.b_y       = offered.b_y;
  assign in_ch.b_w       = offered.b_w;
  assign in_ch.b_h       = offered.b_h;
  assign in_ch.a_trigger = offered.a_trigger;
  assign in_ch.b_trigger = offered.b_trigger;
  assign out_ch.ready    = recv_ready;

  collider_pair_t  pairs_to_send[$];
  contact_result_t expected_results[$];

  // Shadow copy of the per-pair contact bits: bit 0 first side, bit 1 second side.
  logic [1:0] contact_state [PAIR_COUNT] = '{default: 2'b00};

  int send_idle_pct   = 0;
  int recv_stall_pct  = 0;
  int holds_requested = 0;
  int holds_served    = 0;
  int hold_left       = 0;

  int pairs_accepted  = 0;
  int results_checked = 0;
  int mismatch_count  = 0;
  int hit_count       = 0;
  int enter_count     = 0;
  int exit_count      = 0;

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Strict overlap test on sign- or zero-extended Q12.4 values. The caller has
  // already put the circle first for a box-circle pair.
  function automatic logic shapes_overlap(input func_t kind,
                                          input longint ax, ay, aw, ah,
                                          input longint bx, by, bw, bh);
    longint dx, dy, rsum, px, py;
    case (kind)
      FN_CIRC_CIRC: begin
        dx   = ax - bx;
        dy   = ay - by;
        rsum = aw + bw;
        return (dx * dx + dy * dy) < (rsum * rsum);
      end
      FN_BOX_BOX: begin
        return (ax + aw > bx) && (ax < bx + bw) && (ay + ah > by) && (ay < by + bh);
      end
      default: begin
        // Clamp the circle centre onto the box to find the closest point.
        px = (ax < bx) ? bx : ((ax > bx + bw) ? bx + bw : ax);
        py = (ay < by) ? by : ((ay > by + bh) ? by + bh : ay);
        dx = ax - px;
        dy = ay - py;
        return (dx * dx + dy * dy) < (aw * aw);
      end
    endcase
  endfunction

  function automatic event_t side_event(input logic had_contact, input logic touching);
    if (touching) begin
      return had_contact ? EV_STAY : EV_ENTER;
    end
    return had_contact ? EV_EXIT : EV_NONE;
  endfunction

  // Work out the result of one accepted pair and advance the contact bits.
  function automatic contact_result_t predict_contact(input collider_pair_t p);
    contact_result_t r;
    collider_pair_t  s;
    logic [1:0]      bits;
    logic            touching;
    int              slot;
    s = p;
    // Box-circle: swap the sides, trigger flags included, so the circle leads.
    if (p.func == FN_BOX_CIRC) begin
      s.a_x       = p.b_x;
      s.a_y       = p.b_y;
      s.a_w       = p.b_w;
      s.a_h       = p.b_h;
      s.a_trigger = p.b_trigger;
      s.b_x       = p.a_x;
      s.b_y       = p.a_y;
      s.b_w       = p.a_w;
      s.b_h       = p.a_h;
      s.b_trigger = p.a_trigger;
    end
    touching = shapes_overlap(p.func,
                              longint'(s.a_x), longint'(s.a_y),
                              longint'(s.a_w), longint'(s.a_h),
                              longint'(s.b_x), longint'(s.b_y),
                              longint'(s.b_w), longint'(s.b_h));
    slot = int'(p.pair_id) % PAIR_COUNT;
    bits = contact_state[slot];
    r.hit               = touching;
    r.first_event       = side_event(bits[0], touching);
    r.first_is_trigger  = s.a_trigger;
    r.second_event      = side_event(bits[1], touching);
    r.second_is_trigger = s.b_trigger;
    // Both bits end up equal to the overlap flag, whatever they held.
    contact_state[slot] = {2{touching}};
    hit_count   += touching;
    enter_count += (r.first_event == EV_ENTER) + (r.second_event == EV_ENTER);
    exit_count  += (r.first_event == EV_EXIT) + (r.second_event == EV_EXIT);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic collider_pair_t make_pair(input func_t kind, input int id,
                                               input int ax, ay, aw, ah,
                                               input int bx, by, bw, bh,
                                               input int at, bt);
    collider_pair_t p;
    p.func      = kind;
    p.pair_id   = 8'(id);
    p.a_x       = 16'(ax);
    p.a_y       = 16'(ay);
    p.a_w       = 15'(aw);
    p.a_h       = 15'(ah);
    p.b_x       = 16'(bx);
    p.b_y       = 16'(by);
    p.b_w       = 15'(bw);
    p.b_h       = 15'(bh);
    p.a_trigger = 1'(at);
    p.b_trigger = 1'(bt);
    return p;
  endfunction

  // Pick a field extreme; the low 15 bits give the size extremes.
  function automatic logic [15:0] corner_value();
    case ($urandom_range(4))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return 16'hffff;
      default: return 16'h0001;
    endcase
  endfunction

  // Mostly shapes placed close together on a few pair slots, so contacts
  // enter, stay and exit; the rest is raw noise and corner values.
  function automatic collider_pair_t random_pair();
    collider_pair_t p;
    int mode, cx, cy, spread;
    mode        = $urandom_range(99);
    p.func      = func_t'($urandom_range(3));
    p.pair_id   = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(15));
    p.a_trigger = 1'($urandom_range(1));
    p.b_trigger = 1'($urandom_range(1));
    if (mode < 25) begin
      p.a_x = 16'($urandom);
      p.a_y = 16'($urandom);
      p.a_w = 15'($urandom);
      p.a_h = 15'($urandom);
      p.b_x = 16'($urandom);
      p.b_y = 16'($urandom);
      p.b_w = 15'($urandom);
      p.b_h = 15'($urandom);
    end else if (mode < 35) begin
      p.a_x = corner_value();
      p.a_y = corner_value();
      p.a_w = 15'(corner_value());
      p.a_h = 15'(corner_value());
      p.b_x = corner_value();
      p.b_y = corner_value();
      p.b_w = 15'(corner_value());
      p.b_h = 15'(corner_value());
    end else begin
      spread = 1 << $urandom_range(11, 4);
      cx     = int'($urandom_range(65535)) - 32768;
      cy     = int'($urandom_range(65535)) - 32768;
      p.a_x  = 16'(cx + int'($urandom_range(2 * spread)) - spread);
      p.a_y  = 16'(cy + int'($urandom_range(2 * spread)) - spread);
      p.a_w  = 15'($urandom_range(spread));
      p.a_h  = 15'($urandom_range(spread));
      p.b_x  = 16'(cx + int'($urandom_range(2 * spread)) - spread);
      p.b_y  = 16'(cy + int'($urandom_range(2 * spread)) - spread);
      p.b_w  = 15'($urandom_range(spread));
      p.b_h  = 15'($urandom_range(spread));
    end
    return p;
  endfunction

  // Hold the stimulus until the queue is empty and every result is back.
  // Sample away from the rising edge so the driver's updates have settled.
  task automatic wait_drained();
    while (pairs_to_send.size() != 0 || send_valid || expected_results.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic flag_result(input string why, input contact_result_t want,
                             input contact_result_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t: %s: expected hit=%0b first=%0d/%0b second=%0d/%0b, got hit=%0b first=%0d/%0b second=%0d/%0b",
               $realtime, why, want.hit, want.first_event, want.first_is_trigger,
               want.second_event, want.second_is_trigger, got.hit, got.first_event,
               got.first_is_trigger, got.second_event, got.second_is_trigger);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: predict on each transfer, then offer the next pair or idle.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_pairs
    if (!rst_n) begin
      send_valid <= 1'b0;
    end else begin
      if (send_valid && in_ch.ready) begin
        expected_results.push_back(predict_contact(offered));
        pairs_accepted++;
      end
      // Only move on once the current offer has been taken; never drop valid
      // while a pair is still waiting for ready.
      if (!send_valid || in_ch.ready) begin
        if (pairs_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offered    <= pairs_to_send.pop_front();
          send_valid <= 1'b1;
        end else begin
          send_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Long receiver hold-off, counted here so the monitor stays simple.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : hold_results
    if (!rst_n) begin
      hold_left    <= 0;
      holds_served <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_served != holds_requested) begin
      hold_left    <= LONG_HOLD_CYCLES;
      holds_served <= holds_served + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each result transfer against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    contact_result_t want, got;
    if (!rst_n) begin
      recv_ready <= 1'b0;
    end else begin
      if (out_ch.valid && recv_ready) begin
        got.hit               = out_ch.hit;
        got.first_event       = event_t'(out_ch.first_event);
        got.first_is_trigger  = out_ch.first_is_trigger;
        got.second_event      = event_t'(out_ch.second_event);
        got.second_is_trigger = out_ch.second_is_trigger;
        results_checked++;
        if (expected_results.size() == 0) begin
          want = '0;
          flag_result("result with nothing pending", want, got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            flag_result("result mismatch", want, got);
          end
        end
      end
      recv_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus sequence
  // ---------------------------------------------------------------------------
  initial begin : run_sequence
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: contact life cycle, tangent and edge-touching shapes, zero
    // sizes, circle inside box, box-circle swap, coordinate extremes.
    pairs_to_send.push_back(make_pair(FN_CIRC_CIRC, 0, 0, 0, 16, 0, 0, 0, 16, 0, 0, 0));
    pairs_to_send.push_back(make_pair(FN_CIRC_CIRC, 0, 0, 0, 16, 0, 0, 0, 16, 0, 1, 0));
    pairs_to_send.push_back(make_pair(FN_CIRC_CIRC, 0, 0, 0, 16, 0, 1000, 0, 16, 0, 0, 1));
    pairs_to_send.push_back(make_pair(FN_CIRC_CIRC, 0, 0, 0, 16, 0, 1000, 0, 16, 0, 1, 1));
    pairs_to_send.push_back(make_pair(FN_CIRC_CIRC, 1, 5, 5, 0, 0, 5, 5, 0, 0, 0, 0));
    pairs_to_send.push_back(make_pair(FN_CIRC_CIRC, 2, 0, 0, 64, 0, 160, 0, 96, 0, 0, 0));
    pairs_to_send.push_back(make_pair(FN_CIRC_CIRC, 2, 0, 0, 64, 0, 159, 0, 96, 0, 0, 0));
    pairs_to_send.push_back(make_pair(FN_CIRC_CIRC, 3, -32768, -32768, 32767, 32767,
                                      32767, 32767, 32767, 32767, 1, 1));
    pairs_to_send.push_back(make_pair(FN_CIRC_CIRC, 3, -32768, 0, 32767, 0,
                                      32767, 0, 32767, 0, 0, 0));
    pairs_to_send.push_back(make_pair(FN_BOX_BOX, 4, 0, 0, 100, 100, 100, 0, 50, 50, 0, 0));
    pairs_to_send.push_back(make_pair(FN_BOX_BOX, 4, 0, 0, 100, 100, 99, 0, 50, 50, 1, 0));
    pairs_to_send.push_back(make_pair(FN_BOX_BOX, 5, 0, 0, 0, 100, -10, -10, 50, 150, 0, 1));
    pairs_to_send.push_back(make_pair(FN_BOX_BOX, 6, -32768, -32768, 32767, 32767,
                                      32767, 32767, 32767, 32767, 0, 0));
    pairs_to_send.push_back(make_pair(FN_BOX_BOX, 6, -32768, -32768, 32767, 32767,
                                      -2, -2, 32767, 32767, 1, 1));
    pairs_to_send.push_back(make_pair(FN_CIRC_BOX, 7, 50, 50, 1, 0, 0, 0, 100, 100, 0, 0));
    pairs_to_send.push_back(make_pair(FN_CIRC_BOX, 7, 50, 50, 0, 0, 0, 0, 100, 100, 0, 0));
    pairs_to_send.push_back(make_pair(FN_CIRC_BOX, 8, 0, 0, 50, 0, 30, 40, 100, 100, 0, 0));
    pairs_to_send.push_back(make_pair(FN_CIRC_BOX, 8, 0, 0, 51, 0, 30, 40, 100, 100, 0, 0));
    pairs_to_send.push_back(make_pair(FN_BOX_CIRC, 9, 0, 0, 100, 100, 50, 50, 10, 0, 1, 0));
    pairs_to_send.push_back(make_pair(FN_BOX_CIRC, 9, 0, 0, 100, 100, 900, 900, 10, 0, 0, 1));
    pairs_to_send.push_back(make_pair(FN_CIRC_CIRC, 255, 100, 100, 32767, 0,
                                      -100, -100, 32767, 0, 1, 1));
    pairs_to_send.push_back(make_pair(FN_CIRC_BOX, 10, -32768, -32768, 32767, 0,
                                      32767, 32767, 32767, 32767, 0, 0));
    pairs_to_send.push_back(make_pair(FN_BOX_CIRC, 11, -32768, -32768, 32767, 32767,
                                      32767, 32767, 32767, 0, 1, 0));
    wait_drained();

    // Sender mostly busy, receiver stalling most of the time.
    send_idle_pct  = 20;
    recv_stall_pct = 77;
    repeat (RANDOM_PER_PHASE) pairs_to_send.push_back(random_pair());
    wait_drained();

    // Sender idling most of the time, receiver mostly ready.
    send_idle_pct  = 77;
    recv_stall_pct = 20;
    repeat (RANDOM_PER_PHASE) pairs_to_send.push_back(random_pair());
    wait_drained();

    // Full rate both ways, with one long result stall to back up the pipe.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (RANDOM_PER_PHASE) pairs_to_send.push_back(random_pair());
    repeat (50) @(posedge clk);
    holds_requested <= holds_requested + 1;
    wait_drained();

    // Let any stray result show up before the verdict.
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d pair transfers over all four pair kinds: %0d overlaps, %0d enters, %0d exits.",
             pairs_accepted, hit_count, enter_count, exit_count);
    $display("Results checked: %0d, under sender gaps, receiver stalls and a %0d-cycle hold.",
             results_checked, LONG_HOLD_CYCLES);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("Mismatches counted: %0d", mismatch_count);
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin : watchdog
    #2_000_000;
    $display("Timeout with %0d results still pending", expected_results.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- shape_pair_contact_events.f -----
+incdir+rtl/core
rtl/core/spce_pkg.sv
rtl/core/spce_in_if.sv
rtl/core/spce_out_if.sv
rtl/core/spce_overlap.sv
rtl/core/shape_pair_contact_events.sv
tb/shape_pair_contact_events_tb.sv
